/* rtl/core/box_support_point_assert.svh */
// ============================================================================
// Assertion macros for the box support point block
// Shared property forms used by the checks at the end of the top-level RTL module.
// ============================================================================
`ifndef BOX_SUPPORT_POINT_ASSERT_SVH
`define BOX_SUPPORT_POINT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSP_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("box_support_point: same-cycle check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define BSP_ASSERT_AFTER(label, clk, rst, pre, n, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error("box_support_point: delayed check failed");

// The antecedent must have been seen a fixed number of cycles earlier.
`define BSP_ASSERT_PAST(label, clk, rst, now, n, then_cond) \
   label: assert property (@(posedge clk) disable iff (rst) (now) |-> $past(then_cond, n)) \
      else $error("box_support_point: history check failed");

`endif

/* rtl/core/bsp_pkg.sv */
// ============================================================================
// bsp_pkg
// Types, constants and helper functions shared by the support point modules.
// ============================================================================
package bsp_pkg;

   typedef logic signed [31:0] q16_type;
   typedef q16_type [2:0] vec3_type;
   typedef logic signed [33:0] off_type;
   typedef off_type [2:0] off3_type;

   typedef struct packed {
      vec3_type lo;
      vec3_type hi;
   } box_type;

   // One query as it sits in the queue between the front and the back.
   typedef struct packed {
      vec3_type   dir;
      vec3_type   pos;
      q16_type    quat_w;
      q16_type    quat_x;
      q16_type    quat_y;
      q16_type    quat_z;
      q16_type    bias;
      logic [4:0] shift;
      logic       zero;
   } query_type;

   typedef enum logic [2:0] {
      CSR_BOX_MIN_X,
      CSR_BOX_MIN_Y,
      CSR_BOX_MIN_Z,
      CSR_BOX_MAX_X,
      CSR_BOX_MAX_Y,
      CSR_BOX_MAX_Z
   } csr_index_type;

   localparam int NUM_CORNERS = 8;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 33;
   localparam int COR_LAT     = 10;
   localparam int OFF_LAT     = 3 + SQRT_STEPS + 2 + DIV_STEPS + 1;
   localparam int ALIGN_LAT   = OFF_LAT - COR_LAT;
   localparam int TOTAL_LAT   = OFF_LAT + 2;

   // Corner visiting order; bit 0 picks max x, bit 1 max y, bit 2 max z.
   localparam logic [2:0] CORNER_SEL [NUM_CORNERS] =
      '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3};

   function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return 64'(a) * 64'(b);
   endfunction

   function automatic q16_type sat_q16(input logic signed [39:0] v);
      q16_type r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/bsp_front.sv */
// ============================================================================
// bsp_front
// Accepts queries and works out the direction normalising shift.
// ============================================================================
module bsp_front
   import bsp_pkg::*;
(
   input  logic      reset,
   input  logic      start,
   input  q16_type   req_dir_x,
   input  q16_type   req_dir_y,
   input  q16_type   req_dir_z,
   input  q16_type   req_pos_x,
   input  q16_type   req_pos_y,
   input  q16_type   req_pos_z,
   input  q16_type   req_quat_w,
   input  q16_type   req_quat_x,
   input  q16_type   req_quat_y,
   input  q16_type   req_quat_z,
   input  q16_type   req_bias,
   input  logic      queue_full,
   output logic      busy,
   output logic      push,
   output query_type query
);

   logic [31:0] abs_x, abs_y, abs_z, or_word;
   logic [4:0]  msb;

   assign busy = reset | queue_full;
   assign push = start & ~busy;

   // The largest magnitude and the OR of all magnitudes share a leading bit.
   always_comb begin
      abs_x   = req_dir_x[31] ? (~req_dir_x + 32'd1) : req_dir_x;
      abs_y   = req_dir_y[31] ? (~req_dir_y + 32'd1) : req_dir_y;
      abs_z   = req_dir_z[31] ? (~req_dir_z + 32'd1) : req_dir_z;
      or_word = abs_x | abs_y | abs_z;
      msb     = '0;
      for (int b = 0; b < 32; b++) begin
         if (or_word[b]) begin
            msb = 5'(b);
         end
      end
   end

   always_comb begin
      query.dir    = {req_dir_z, req_dir_y, req_dir_x};
      query.pos    = {req_pos_z, req_pos_y, req_pos_x};
      query.quat_w = req_quat_w;
      query.quat_x = req_quat_x;
      query.quat_y = req_quat_y;
      query.quat_z = req_quat_z;
      query.bias   = req_bias;
      query.zero   = (or_word == 32'd0);
      query.shift  = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
   end

endmodule

/* rtl/core/bsp_queue.sv */
// ============================================================================
// bsp_queue
// Two-entry queue between the front and the back of the block.
// ============================================================================
module bsp_queue
   import bsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  query_type wr_data,
   output logic      full,
   output logic      pop,
   output query_type rd_data
);

   query_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign pop     = (count_ff != 2'd0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/bsp_corner.sv */
// ============================================================================
// bsp_corner
// Rotates and translates the box corners and picks the furthest one.
// ============================================================================
module bsp_corner
   import bsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  query_type in_query,
   input  box_type   box,
   output logic      out_valid,
   output vec3_type  out_best
);

   logic [COR_LAT-1:0] vld_ff;
   vec3_type           dir_d_ff [5];
   vec3_type           pos_d_ff [4];
   logic signed [63:0] qp_ff [9];
   logic signed [63:0] qp_in [9];
   logic signed [31:0] mat_ff [3][3];
   logic signed [31:0] mat_in [3][3];
   logic signed [63:0] cp_ff [3][3][2];
   logic signed [63:0] cp_in [3][3][2];
   logic signed [33:0] tm_ff [3][3][2];
   logic signed [33:0] tm_in [3][3][2];
   logic signed [31:0] w5_ff [NUM_CORNERS][3];
   logic signed [31:0] w5_in [NUM_CORNERS][3];
   logic signed [63:0] dp_ff [NUM_CORNERS][3];
   logic signed [63:0] dp_in [NUM_CORNERS][3];
   logic signed [31:0] w6_ff [NUM_CORNERS][3];
   logic signed [65:0] dot_ff [NUM_CORNERS];
   logic signed [65:0] dot_in [NUM_CORNERS];
   logic signed [31:0] w7_ff [NUM_CORNERS][3];
   logic signed [65:0] l1_dot_ff [4];
   logic signed [65:0] l1_dot_in [4];
   logic signed [31:0] l1_w_ff [4][3];
   logic signed [31:0] l1_w_in [4][3];
   logic signed [65:0] l2_dot_ff [2];
   logic signed [65:0] l2_dot_in [2];
   logic signed [31:0] l2_w_ff [2][3];
   logic signed [31:0] l2_w_in [2][3];
   vec3_type           best_ff, best_in;

   function automatic logic signed [39:0] rnd29(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd268435456;
      return 40'($signed(t[62:29]));
   endfunction

   function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[63:30];
   endfunction

   assign out_valid = vld_ff[COR_LAT-1];
   assign out_best  = best_ff;

   // Doubled quaternion products.
   always_comb begin
      qp_in[0] = smul(in_query.quat_x, in_query.quat_x);
      qp_in[1] = smul(in_query.quat_y, in_query.quat_y);
      qp_in[2] = smul(in_query.quat_z, in_query.quat_z);
      qp_in[3] = smul(in_query.quat_x, in_query.quat_y);
      qp_in[4] = smul(in_query.quat_x, in_query.quat_z);
      qp_in[5] = smul(in_query.quat_y, in_query.quat_z);
      qp_in[6] = smul(in_query.quat_w, in_query.quat_x);
      qp_in[7] = smul(in_query.quat_w, in_query.quat_y);
      qp_in[8] = smul(in_query.quat_w, in_query.quat_z);
   end

   // Rotation matrix in Q2.30, each entry saturated.
   always_comb begin
      logic signed [39:0] r [9];
      logic signed [39:0] one;
      one = 40'sd1073741824;
      for (int k = 0; k < 9; k++) begin
         r[k] = rnd29(qp_ff[k]);
      end
      mat_in[0][0] = sat_q16(one - (r[1] + r[2]));
      mat_in[0][1] = sat_q16(r[3] - r[8]);
      mat_in[0][2] = sat_q16(r[4] + r[7]);
      mat_in[1][0] = sat_q16(r[3] + r[8]);
      mat_in[1][1] = sat_q16(one - (r[0] + r[2]));
      mat_in[1][2] = sat_q16(r[5] - r[6]);
      mat_in[2][0] = sat_q16(r[4] - r[7]);
      mat_in[2][1] = sat_q16(r[5] + r[6]);
      mat_in[2][2] = sat_q16(one - (r[0] + r[1]));
   end

   // Every matrix entry against both the lower and the upper bound of its axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cp_in[i][j][0] = smul(mat_ff[i][j], box.lo[j]);
            cp_in[i][j][1] = smul(mat_ff[i][j], box.hi[j]);
            tm_in[i][j][0] = rnd30(cp_ff[i][j][0]);
            tm_in[i][j][1] = rnd30(cp_ff[i][j][1]);
         end
      end
   end

   always_comb begin
      logic [2:0]         s;
      logic signed [39:0] acc;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         s = CORNER_SEL[k];
         for (int i = 0; i < 3; i++) begin
            acc = 40'($signed(pos_d_ff[3][i])) + 40'(tm_ff[i][0][s[0]])
                + 40'(tm_ff[i][1][s[1]]) + 40'(tm_ff[i][2][s[2]]);
            w5_in[k][i] = sat_q16(acc);
            dp_in[k][i] = smul(dir_d_ff[4][i], w5_ff[k][i]);
         end
         dot_in[k] = 66'(dp_ff[k][0]) + 66'(dp_ff[k][1]) + 66'(dp_ff[k][2]);
      end
   end

   // Pairwise selection; the later corner of a pair wins only when strictly ahead.
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         if (dot_ff[2*p+1] > dot_ff[2*p]) begin
            l1_dot_in[p] = dot_ff[2*p+1];
            l1_w_in[p]   = w7_ff[2*p+1];
         end else begin
            l1_dot_in[p] = dot_ff[2*p];
            l1_w_in[p]   = w7_ff[2*p];
         end
      end
      for (int p = 0; p < 2; p++) begin
         if (l1_dot_ff[2*p+1] > l1_dot_ff[2*p]) begin
            l2_dot_in[p] = l1_dot_ff[2*p+1];
            l2_w_in[p]   = l1_w_ff[2*p+1];
         end else begin
            l2_dot_in[p] = l1_dot_ff[2*p];
            l2_w_in[p]   = l1_w_ff[2*p];
         end
      end
      for (int i = 0; i < 3; i++) begin
         best_in[i] = (l2_dot_ff[1] > l2_dot_ff[0]) ? l2_w_ff[1][i] : l2_w_ff[0][i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[COR_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      dir_d_ff[0] <= in_query.dir;
      pos_d_ff[0] <= in_query.pos;
      for (int t = 1; t < 5; t++) begin
         dir_d_ff[t] <= dir_d_ff[t-1];
      end
      for (int t = 1; t < 4; t++) begin
         pos_d_ff[t] <= pos_d_ff[t-1];
      end
      qp_ff     <= qp_in;
      mat_ff    <= mat_in;
      cp_ff     <= cp_in;
      tm_ff     <= tm_in;
      w5_ff     <= w5_in;
      dp_ff     <= dp_in;
      w6_ff     <= w5_ff;
      dot_ff    <= dot_in;
      w7_ff     <= w6_ff;
      l1_dot_ff <= l1_dot_in;
      l1_w_ff   <= l1_w_in;
      l2_dot_ff <= l2_dot_in;
      l2_w_ff   <= l2_w_in;
      best_ff   <= best_in;
   end

endmodule

/* rtl/core/bsp_offset.sv */
// ============================================================================
// bsp_offset
// Scales the normalised direction by the bias: square root, then division.
// ============================================================================
module bsp_offset
   import bsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  query_type in_query,
   output logic      out_valid,
   output off3_type  out_off
);

   typedef struct packed {
      vec3_type d;
      q16_type  bias;
      logic     zero;
   } side_type;

   logic [OFF_LAT-1:0] vld_ff;
   side_type           s1_ff, s1_in, s2_ff, s3_ff;
   logic [63:0]        sq_ff [3];
   logic [63:0]        sq_in [3];
   logic [63:0]        n_ff, n_in;
   logic [63:0]        rem_ff [SQRT_STEPS];
   logic [63:0]        root_ff [SQRT_STEPS];
   side_type           sside_ff [SQRT_STEPS];
   logic [32:0]        len_ff, len_in;
   logic signed [63:0] num_ff [3];
   logic signed [63:0] num_in [3];
   logic               zero36_ff;
   logic [62:0]        nn_ff [3];
   logic [62:0]        nn_in [3];
   logic               neg_ff [3];
   logic [32:0]        len37_ff;
   logic               zero37_ff;
   logic [32:0]        dr_ff [DIV_STEPS][3];
   logic [32:0]        dq_ff [DIV_STEPS][3];
   logic [62:0]        dn_ff [DIV_STEPS][3];
   logic               dneg_ff [DIV_STEPS][3];
   logic [32:0]        dlen_ff [DIV_STEPS];
   logic               dzero_ff [DIV_STEPS];
   off3_type           off_ff, off_in;

   assign out_valid = vld_ff[OFF_LAT-1];
   assign out_off   = off_ff;

   // Scale the direction up until its largest magnitude reaches bit 30.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_in.d[i] = in_query.dir[i] << in_query.shift;
         sq_in[i]   = smul(s1_ff.d[i], s1_ff.d[i]);
      end
      s1_in.bias = in_query.bias;
      s1_in.zero = in_query.zero;
      n_in       = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // Digit-by-digit square root, one result bit per stage.
   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * s);
      logic [63:0] rem_prev, root_prev, trial, rem_in, root_in;
      side_type    side_prev;
      if (s == 0) begin : g_first
         assign rem_prev  = n_ff;
         assign root_prev = '0;
         assign side_prev = s3_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign side_prev = sside_ff[s-1];
      end
      always_comb begin
         trial = root_prev + STEP_BIT;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[s]   <= rem_in;
         root_ff[s]  <= root_in;
         sside_ff[s] <= side_prev;
      end
   end

   // Round the root to nearest and form the numerators.
   always_comb begin
      logic [63:0] mag;
      len_in = root_ff[SQRT_STEPS-1][32:0]
             + 33'(rem_ff[SQRT_STEPS-1] > root_ff[SQRT_STEPS-1]);
      for (int i = 0; i < 3; i++) begin
         num_in[i] = smul(sside_ff[SQRT_STEPS-1].bias, sside_ff[SQRT_STEPS-1].d[i]);
         mag       = num_ff[i][63] ? (~num_ff[i] + 64'd1) : num_ff[i];
         nn_in[i]  = mag[62:0] + 63'(len_ff >> 1);
      end
   end

   // Restoring division, one quotient bit per stage and lane.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int NBIT = DIV_STEPS - 1 - j;
      logic [32:0] r_prev [3];
      logic [32:0] q_prev [3];
      logic [62:0] n_prev [3];
      logic        neg_prev [3];
      logic [32:0] len_prev;
      logic        zero_prev;
      logic [32:0] r_in [3];
      logic [32:0] q_in [3];
      if (j == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               r_prev[l]   = 33'(nn_ff[l][62:DIV_STEPS]);
               q_prev[l]   = '0;
               n_prev[l]   = nn_ff[l];
               neg_prev[l] = neg_ff[l];
            end
            len_prev  = len37_ff;
            zero_prev = zero37_ff;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               r_prev[l]   = dr_ff[j-1][l];
               q_prev[l]   = dq_ff[j-1][l];
               n_prev[l]   = dn_ff[j-1][l];
               neg_prev[l] = dneg_ff[j-1][l];
            end
            len_prev  = dlen_ff[j-1];
            zero_prev = dzero_ff[j-1];
         end
      end
      always_comb begin
         logic [33:0] t;
         logic        ge;
         for (int l = 0; l < 3; l++) begin
            t  = {r_prev[l], n_prev[l][NBIT]};
            ge = (t >= {1'b0, len_prev});
            r_in[l] = ge ? 33'(t - {1'b0, len_prev}) : t[32:0];
            q_in[l] = {q_prev[l][31:0], ge};
         end
      end
      always_ff @(posedge clock) begin
         for (int l = 0; l < 3; l++) begin
            dr_ff[j][l]   <= r_in[l];
            dq_ff[j][l]   <= q_in[l];
            dn_ff[j][l]   <= n_prev[l];
            dneg_ff[j][l] <= neg_prev[l];
         end
         dlen_ff[j]  <= len_prev;
         dzero_ff[j] <= zero_prev;
      end
   end

   // A zero direction contributes no offset.
   always_comb begin
      off_type q;
      for (int l = 0; l < 3; l++) begin
         q = 34'(dq_ff[DIV_STEPS-1][l]);
         if (dzero_ff[DIV_STEPS-1]) begin
            off_in[l] = '0;
         end else begin
            off_in[l] = dneg_ff[DIV_STEPS-1][l] ? -q : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[OFF_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s2_ff     <= s1_ff;
      s3_ff     <= s2_ff;
      sq_ff     <= sq_in;
      n_ff      <= n_in;
      len_ff    <= len_in;
      num_ff    <= num_in;
      zero36_ff <= sside_ff[SQRT_STEPS-1].zero;
      nn_ff     <= nn_in;
      len37_ff  <= len_ff;
      zero37_ff <= zero36_ff;
      for (int i = 0; i < 3; i++) begin
         neg_ff[i] <= num_ff[i][63];
      end
      off_ff <= off_in;
   end

endmodule

/* rtl/core/box_support_point.sv */
// Throughput: one query per clock cycle, sustained; busy stays low outside reset.
// The result path runs through the 32-stage square root and the 33-stage divider pipelines.
// Reset clears all valid flags, the queue and the six box registers (to zero).
// Results cannot be held off: each is shown for one cycle with rsp_valid high.
// ============================================================================
// box_support_point
// Support point of a configured oriented box for collision queries.
// ============================================================================
`include "box_support_point_assert.svh"

module box_support_point
   import bsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Query channel
   input  logic        start,
   output logic        busy,
   input  q16_type     req_dir_x,
   input  q16_type     req_dir_y,
   input  q16_type     req_dir_z,
   input  q16_type     req_pos_x,
   input  q16_type     req_pos_y,
   input  q16_type     req_pos_z,
   input  q16_type     req_quat_w,
   input  q16_type     req_quat_x,
   input  q16_type     req_quat_y,
   input  q16_type     req_quat_z,
   input  q16_type     req_bias,
   // Result channel
   output logic        rsp_valid,
   output q16_type     rsp_support_x,
   output q16_type     rsp_support_y,
   output q16_type     rsp_support_z,
   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // The front classifies each query as it arrives and pushes it into the
   // queue. The back drains the queue every cycle into two independent
   // pipelines: one rotates the box corners and picks the furthest corner,
   // the other normalises the direction and scales it by the bias. The
   // shorter corner pipeline is delayed here so that both meet in the final
   // addition stage.

   logic      push, queue_full, pop;
   query_type front_query, back_query;
   box_type   box_ff, box_in;
   logic      cor_valid, off_valid;
   vec3_type  cor_best;
   off3_type  off_val;

   vec3_type  best_d_ff [ALIGN_LAT];
   logic      best_v_ff [ALIGN_LAT];

   logic      rsp_valid_ff;
   vec3_type  rsp_ff, rsp_in;

   // A register transfer is taken whenever the block is out of reset.
   assign csr_ready = ~reset;

   always_comb begin
      box_in = box_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BOX_MIN_X: begin box_in.lo[0] = csr_data; end
            CSR_BOX_MIN_Y: begin box_in.lo[1] = csr_data; end
            CSR_BOX_MIN_Z: begin box_in.lo[2] = csr_data; end
            CSR_BOX_MAX_X: begin box_in.hi[0] = csr_data; end
            CSR_BOX_MAX_Y: begin box_in.hi[1] = csr_data; end
            CSR_BOX_MAX_Z: begin box_in.hi[2] = csr_data; end
            default: begin box_in = box_ff; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else begin
         box_ff <= box_in;
      end
   end

   bsp_front u_front (
      .reset      (reset),
      .start      (start),
      .req_dir_x  (req_dir_x),
      .req_dir_y  (req_dir_y),
      .req_dir_z  (req_dir_z),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .req_bias   (req_bias),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .query      (front_query)
   );

   bsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_query),
      .full    (queue_full),
      .pop     (pop),
      .rd_data (back_query)
   );

   bsp_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .in_query  (back_query),
      .box       (box_ff),
      .out_valid (cor_valid),
      .out_best  (cor_best)
   );

   bsp_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .in_query  (back_query),
      .out_valid (off_valid),
      .out_off   (off_val)
   );

   // Delay line that lines the chosen corner up with its offset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < ALIGN_LAT; t++) begin
            best_v_ff[t] <= 1'b0;
         end
      end else begin
         best_v_ff[0] <= cor_valid;
         for (int t = 1; t < ALIGN_LAT; t++) begin
            best_v_ff[t] <= best_v_ff[t-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      best_d_ff[0] <= cor_best;
      for (int t = 1; t < ALIGN_LAT; t++) begin
         best_d_ff[t] <= best_d_ff[t-1];
      end
   end

   // Final sum, saturated to the output range.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsp_in[i] = sat_q16(40'($signed(best_d_ff[ALIGN_LAT-1][i])) + 40'(off_val[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= off_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_support_x = rsp_ff[0];
   assign rsp_support_y = rsp_ff[1];
   assign rsp_support_z = rsp_ff[2];

   // The back drains the queue every cycle, so it never fills up.
   `BSP_ASSERT_SAME(a_queue_never_full, clock, reset, 1'b1, !busy)
   // Both back pipelines deliver the same query in the same cycle.
   `BSP_ASSERT_SAME(a_paths_aligned, clock, reset, 1'b1, off_valid == best_v_ff[ALIGN_LAT-1])
   // Every accepted query gives its result after the fixed latency.
   `BSP_ASSERT_AFTER(a_fixed_latency, clock, reset, start && !busy, 73, rsp_valid)
   // No result appears without a query taken that long before.
   `BSP_ASSERT_PAST(a_no_spurious, clock, reset, rsp_valid, 73, start && !busy)

endmodule

/* bench/tb_box_support_point.sv */
// ----------------------------------------------------------------------------
// Testbench for the box support point block
// Drives support queries through a randomly idling driver and checks every
// result strobe against a predictor of the oriented box support point, over
// several box settings written between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_box_support_point
   import bsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Indices past the end of the register map; writes to them must be ignored.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   localparam int  DRAIN_CYCLES = 100;      // comfortably above the block's latency
   localparam int  CYCLE_LIMIT  = 600000;
   localparam int  RANDOM_ITEMS = 2000;
   localparam q16_type Q30_ONE  = 32'sd1073741824;
   localparam longint S32_MAX   = 64'sd2147483647;
   localparam longint S32_MIN   = -64'sd2147483648;

   // One support query as the driver presents it.
   typedef struct {
      q16_type dir [3];
      q16_type pos [3];
      q16_type qw, qx, qy, qz;
      q16_type bias;
   } query_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   q16_type     req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   q16_type     req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   q16_type     req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   q16_type     req_bias = '0;
   logic        rsp_valid;
   q16_type     rsp_support_x, rsp_support_y, rsp_support_z;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Testbench copy of the box registers: index 0..2 lower corner, 3..5 upper.
   longint box_reg [6];

   query_item_type pending_queries [$];
   vec3_type       expected_points [$];
   query_item_type current_query;
   int             gap_left = 0;
   int             error_count = 0;
   int             queries_sent = 0;
   int             points_checked = 0;
   int             cycle_count = 0;

   box_support_point dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint clamp32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // Rounds half up while dropping s fraction bits; >>> floors a signed value.
   function automatic longint round_up_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Square root of a 64-bit value, rounded to the nearest integer.
   function automatic longint unsigned root_nearest(input longint unsigned n);
      longint unsigned rest, root, probe;
      rest = n;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      if (rest > root) root++;
      return root;
   endfunction

   // Works out the support point of the rotated and shifted box for one query.
   function automatic vec3_type support_point(input query_item_type q);
      longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint rot [3][3];
      longint corner [3];
      longint world [3];
      longint best [3];
      longint d [3];
      longint offset [3];
      longint acc, mag, num, quo;
      longint unsigned sumsq, len;
      logic signed [127:0] dot, best_dot;
      logic [2:0] pick;
      vec3_type result;
      // Corner order: bit 0 picks max x, bit 1 max y, bit 2 max z.
      logic [2:0] visit [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3};

      w = q.qw; x = q.qx; y = q.qy; z = q.qz;
      xx = round_up_shift(x * x, 29); yy = round_up_shift(y * y, 29);
      zz = round_up_shift(z * z, 29); xy = round_up_shift(x * y, 29);
      xz = round_up_shift(x * z, 29); yz = round_up_shift(y * z, 29);
      wx = round_up_shift(w * x, 29); wy = round_up_shift(w * y, 29);
      wz = round_up_shift(w * z, 29);
      rot[0][0] = Q30_ONE - (yy + zz); rot[0][1] = xy - wz; rot[0][2] = xz + wy;
      rot[1][0] = xy + wz; rot[1][1] = Q30_ONE - (xx + zz); rot[1][2] = yz - wx;
      rot[2][0] = xz - wy; rot[2][1] = yz + wx; rot[2][2] = Q30_ONE - (xx + yy);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rot[i][j] = clamp32(rot[i][j]);

      best_dot = '0;
      for (int k = 0; k < 8; k++) begin
         pick = visit[k];
         for (int j = 0; j < 3; j++)
            corner[j] = pick[j] ? box_reg[3 + j] : box_reg[j];
         dot = '0;
         for (int i = 0; i < 3; i++) begin
            acc = longint'(q.pos[i]);
            for (int j = 0; j < 3; j++)
               acc += round_up_shift(rot[i][j] * corner[j], 30);
            world[i] = clamp32(acc);
            dot += 128'(longint'(q.dir[i])) * 128'(world[i]);
         end
         // A later corner must be strictly better to take over.
         if (k == 0 || dot > best_dot) begin
            best_dot = dot;
            best = world;
         end
      end

      // Bias offset along the normalised direction; nothing for a zero direction.
      mag = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = q.dir[i];
         offset[i] = 0;
         if ((d[i] < 0 ? -d[i] : d[i]) > mag) mag = d[i] < 0 ? -d[i] : d[i];
      end
      if (mag != 0) begin
         while (mag < Q30_ONE) begin
            for (int i = 0; i < 3; i++) d[i] = d[i] * 2;
            mag = mag * 2;
         end
         sumsq = 0;
         for (int i = 0; i < 3; i++) sumsq += longint'(d[i] * d[i]);
         len = root_nearest(sumsq);
         for (int i = 0; i < 3; i++) begin
            num = longint'(q.bias) * d[i];
            quo = longint'((unsigned'(num < 0 ? -num : num) + len / 2) / len);
            offset[i] = num < 0 ? -quo : quo;
         end
      end
      for (int i = 0; i < 3; i++)
         result[i] = q16_type'(clamp32(best[i] + offset[i]));
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued queries with random gaps. A transfer happens
   // at an edge where start is high and busy is low; the expected point is
   // worked out at that moment, so the box registers it sees are current.
   // ---------------------------------------------------------------------

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_points = {expected_points, support_point(current_query)};
            queries_sent++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_queries.size() > 0) begin
               current_query = pending_queries.pop_front();
               req_dir_x  <= current_query.dir[0];
               req_dir_y  <= current_query.dir[1];
               req_dir_z  <= current_query.dir[2];
               req_pos_x  <= current_query.pos[0];
               req_pos_y  <= current_query.pos[1];
               req_pos_z  <= current_query.pos[2];
               req_quat_w <= current_query.qw;
               req_quat_x <= current_query.qx;
               req_quat_y <= current_query.qy;
               req_quat_z <= current_query.qz;
               req_bias   <= current_query.bias;
               start <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: each strobed result is a transfer and is checked against the
   // oldest expected point.
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      vec3_type want;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            report_mismatch("result strobe with no query outstanding");
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (rsp_support_x !== want[0])
               report_mismatch($sformatf("support_x got %0d want %0d", rsp_support_x, want[0]));
            if (rsp_support_y !== want[1])
               report_mismatch($sformatf("support_y got %0d want %0d", rsp_support_y, want[1]));
            if (rsp_support_z !== want[2])
               report_mismatch($sformatf("support_z got %0d want %0d", rsp_support_z, want[2]));
         end
      end
   end

   // Watchdog against a hung handshake or a missing result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic q16_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         1, 2:    return $urandom;
         3:       return 0;
         default: return q16_type'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   function automatic q16_type rand_quat_part();
      return q16_type'(longint'($urandom_range(0, 32'h80000000)) - Q30_ONE);
   endfunction

   function automatic query_item_type make_query(input q16_type dx, dy, dz, px, py, pz,
                                                 input q16_type w, x, y, z, b);
      query_item_type q;
      q.dir = '{dx, dy, dz};
      q.pos = '{px, py, pz};
      q.qw = w; q.qx = x; q.qy = y; q.qz = z;
      q.bias = b;
      return q;
   endfunction

   function automatic query_item_type random_query();
      query_item_type q;
      for (int i = 0; i < 3; i++) begin
         q.dir[i] = rand_coord();
         q.pos[i] = rand_coord();
      end
      q.bias = rand_coord();
      q.qw = 0; q.qx = 0; q.qy = 0; q.qz = 0;
      case ($urandom_range(0, 3))
         0: begin
            // A half turn about one axis, or identity.
            case ($urandom_range(0, 3))
               0: q.qw = $urandom_range(0, 1) ? Q30_ONE : -Q30_ONE;
               1: q.qx = $urandom_range(0, 1) ? Q30_ONE : -Q30_ONE;
               2: q.qy = $urandom_range(0, 1) ? Q30_ONE : -Q30_ONE;
               3: q.qz = $urandom_range(0, 1) ? Q30_ONE : -Q30_ONE;
            endcase
         end
         1: begin
            q.qw = 32'sd759250125;
            q.qz = $urandom_range(0, 1) ? 32'sd759250125 : -32'sd759250125;
         end
         default: begin
            q.qw = rand_quat_part(); q.qx = rand_quat_part();
            q.qy = rand_quat_part(); q.qz = rand_quat_part();
         end
      endcase
      return q;
   endfunction

   // Appends one query to the tail of the pending list.
   task automatic enqueue_query(input query_item_type q);
      pending_queries = {pending_queries, q};
   endtask

   // Registers are written at the rising edge, held until ready is seen.
   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index < 3'd6) box_reg[index] = longint'(signed'(value));
      csr_valid <= 1'b0;
   endtask

   task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
      write_csr(CSR_BOX_MIN_X, lx);
      write_csr(CSR_BOX_MIN_Y, ly);
      write_csr(CSR_BOX_MIN_Z, lz);
      write_csr(CSR_BOX_MAX_X, hx);
      write_csr(CSR_BOX_MAX_Y, hy);
      write_csr(CSR_BOX_MAX_Z, hz);
   endtask

   // The sender pauses here until every expected point has come back, then
   // lets the pipeline drain before any register may change.
   task automatic wait_quiet();
      @(negedge clock);
      while (pending_queries.size() > 0 || start || expected_points.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) begin
         @(negedge clock);
         enqueue_query(random_query());
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      for (int i = 0; i < 6; i++) box_reg[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // With the box still at its reset value every corner is the position.
      @(negedge clock);
      enqueue_query(make_query(32'sh10000, 0, 0, 32'sh7fffffff, 32'sh80000000, 0,
                               Q30_ONE, 0, 0, 0, 32'sh10000));
      wait_quiet();

      // A unit box centred on the origin for the directed queries.
      set_box(32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h00010000, 32'h00010000, 32'h00010000);
      @(negedge clock);
      // Zero direction: the first corner wins and the bias is dropped.
      enqueue_query(make_query(0, 0, 0, 32'sh50000, 0, 0, Q30_ONE, 0, 0, 0, 32'sh7fffffff));
      // Ties along one axis go to the earliest corner.
      enqueue_query(make_query(32'sh10000, 0, 0, 0, 0, 0, Q30_ONE, 0, 0, 0, 0));
      enqueue_query(make_query(0, 32'sh80000000, 0, 0, 0, 0, Q30_ONE, 0, 0, 0, 0));
      enqueue_query(make_query(0, 0, 32'sh7fffffff, 0, 0, 0, Q30_ONE, 0, 0, 0, 0));
      // Diagonal directions reaching the remaining corners.
      enqueue_query(make_query(1, 1, 1, 0, 0, 0, Q30_ONE, 0, 0, 0, 32'sh20000));
      enqueue_query(make_query(-1, -1, -1, 0, 0, 0, Q30_ONE, 0, 0, 0, -32'sh20000));
      enqueue_query(make_query(-1, 1, 1, 0, 0, 0, Q30_ONE, 0, 0, 0, 32'sh7fffffff));
      enqueue_query(make_query(1, -1, 1, 0, 0, 0, Q30_ONE, 0, 0, 0, 32'sh80000000));
      enqueue_query(make_query(1, 1, -1, 0, 0, 0, Q30_ONE, 0, 0, 0, 0));
      // Rotations by each pure axis and a negated identity.
      enqueue_query(make_query(32'sh10000, 32'sh8000, 1, 0, 0, 0, 0, Q30_ONE, 0, 0, 0));
      enqueue_query(make_query(32'sh10000, 32'sh8000, 1, 0, 0, 0, 0, 0, Q30_ONE, 0, 0));
      enqueue_query(make_query(32'sh10000, 32'sh8000, 1, 0, 0, 0, 0, 0, 0, -Q30_ONE, 0));
      enqueue_query(make_query(3, -5, 7, 0, 0, 0, -Q30_ONE, 0, 0, 0, 32'sh10000));
      // Non-unit quaternion: every part at its extreme, the matrix saturates.
      enqueue_query(make_query(1, 2, 3, 0, 0, 0, Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE, 0));
      enqueue_query(make_query(-7, 2, 3, 0, 0, 0, -Q30_ONE, -Q30_ONE, Q30_ONE,
                               -Q30_ONE, 32'sh10000));
      // Output saturation at both ends from position plus bias.
      enqueue_query(make_query(1, 1, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                               Q30_ONE, 0, 0, 0, 32'sh7fffffff));
      enqueue_query(make_query(1, 1, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                               Q30_ONE, 0, 0, 0, 32'sh80000000));
      enqueue_query(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
                               0, 0, 0, Q30_ONE, 0, 0, 0, 32'sh7fffffff));
      enqueue_query(make_query(32'sh7fffffff, 32'sh80000000, 0, 32'sh12345678,
                               -32'sh12345678, 0, Q30_ONE, 0, 0, 0, -32'sh10000));
      wait_quiet();

      // Writes to the unused indices must leave the box alone.
      write_csr(CSR_SPARE_LO, 32'h7fffffff);
      write_csr(CSR_SPARE_HI, 32'h80000000);

      // Random phases over a run of box settings, extremes and an inverted box.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: ;  // keep the unit box
            1: set_box(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
            2: set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000);
            3: set_box(32'h00030000, 32'h00020000, 32'h00010000,
                       32'hfffd0000, 32'hfffe0000, 32'hffff0000);
            4: set_box(32'h00000000, 32'h00000000, 32'h00000000,
                       32'h00000000, 32'h00000000, 32'h00000000);
            default: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         if (phase == 4) begin
            write_csr(CSR_SPARE_LO, $urandom);
            write_csr(CSR_SPARE_HI, $urandom);
         end
         queue_random(RANDOM_ITEMS / 8);
         wait_quiet();
      end

      $display("Sent %0d support queries across nine box settings, %0d results checked.",
               queries_sent, points_checked);
      $display("Covered zero and tied directions, saturation, inverted boxes and spare indices.");
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", error_count,
                  expected_points.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
